// ===== sv/vfps_pkg.sv =====
`timescale 1ns / 1ps
// vfps_pkg: types, event codes and milestone codes for the frame proof sequencer
// used by every module of the block; depends on nothing

package vfps_pkg;

   localparam int unsigned OP_WIDTH        = 4;
   localparam int unsigned DATA_WIDTH      = 32;
   localparam int unsigned MS_WIDTH        = 2;
   localparam int unsigned CSR_INDEX_WIDTH = 1;

   localparam logic [OP_WIDTH-1:0] OP_START      = 4'd0;
   localparam logic [OP_WIDTH-1:0] OP_STOP       = 4'd1;
   localparam logic [OP_WIDTH-1:0] OP_SELECT     = 4'd2;
   localparam logic [OP_WIDTH-1:0] OP_INPUT_RES  = 4'd3;
   localparam logic [OP_WIDTH-1:0] OP_DECODED    = 4'd4;
   localparam logic [OP_WIDTH-1:0] OP_RSV_OUTPUT = 4'd5;
   localparam logic [OP_WIDTH-1:0] OP_OUTPUT_RES = 4'd6;
   localparam logic [OP_WIDTH-1:0] OP_ENCODED    = 4'd7;
   localparam logic [OP_WIDTH-1:0] OP_RSV_MS     = 4'd8;
   localparam logic [OP_WIDTH-1:0] OP_COMMIT_MS  = 4'd9;

   localparam logic [MS_WIDTH-1:0] MS_NONE    = 2'd0;
   localparam logic [MS_WIDTH-1:0] MS_INPUT   = 2'd1;
   localparam logic [MS_WIDTH-1:0] MS_DECODED = 2'd2;
   localparam logic [MS_WIDTH-1:0] MS_ENCODED = 2'd3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOURCE_GEN = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WATERMARK  = 1'd1;

   typedef struct packed {
      logic [OP_WIDTH-1:0]   op;
      logic [DATA_WIDTH-1:0] generation;
      logic [DATA_WIDTH-1:0] sequence_req;
      logic                  is_keyframe;
      logic                  ok;
      logic [MS_WIDTH-1:0]   milestone_in;
   } req_word_type;

   typedef struct packed {
      logic                accepted;
      logic [MS_WIDTH-1:0] milestone_out;
      logic                armed;
      logic                complete;
   } rsp_word_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] expected_gen;
      logic [DATA_WIDTH-1:0] watermark;
   } cfg_type;

endpackage

// ===== sv/vfps_csr.sv =====
`timescale 1ns / 1ps
// vfps_csr: source generation and watermark registers behind the csr write port
// depends on vfps_pkg

module vfps_csr
   import vfps_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]      csr_data,
   output cfg_type                    cfg
);

   logic [DATA_WIDTH-1:0] source_gen_ff;
   logic [DATA_WIDTH-1:0] source_gen_in;
   logic [DATA_WIDTH-1:0] watermark_ff;
   logic [DATA_WIDTH-1:0] watermark_in;
   logic                  write_en;

   assign csr_ready = !reset;
   assign write_en  = csr_valid && csr_ready;

   always_comb begin
      source_gen_in = source_gen_ff;
      watermark_in  = watermark_ff;
      if (write_en) begin
         unique case (csr_index)
            CSR_SOURCE_GEN: source_gen_in = csr_data;
            CSR_WATERMARK:  watermark_in  = csr_data;
            default: begin
               source_gen_in = source_gen_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_gen_ff <= '0;
         watermark_ff  <= '0;
      end else begin
         source_gen_ff <= source_gen_in;
         watermark_ff  <= watermark_in;
      end
   end

   assign cfg.expected_gen = source_gen_ff;
   assign cfg.watermark    = watermark_ff;

endmodule

// ===== sv/vfps_engine.sv =====
`timescale 1ns / 1ps
// vfps_engine: sequencer state and the per-event update and result logic
// depends on vfps_pkg

module vfps_engine
   import vfps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_word_type word,
   input  cfg_type      cfg,
   output rsp_word_type result
);

   logic                  active_ff,    active_in;
   logic [DATA_WIDTH-1:0] chosen_ff,    chosen_in;
   logic                  input_ff,     input_in;
   logic                  decode_ff,    decode_in;
   logic                  out_held_ff,  out_held_in;
   logic                  out_done_ff,  out_done_in;
   logic                  encode_ff,    encode_in;
   logic [MS_WIDTH-1:0]   committed_ff, committed_in;
   logic [MS_WIDTH-1:0]   reserved_ff,  reserved_in;
   logic                  acc;
   logic [MS_WIDTH-1:0]   ms_out;
   logic                  none_chosen;

   assign none_chosen = (chosen_ff == '0);

   always_comb begin
      active_in    = active_ff;
      chosen_in    = chosen_ff;
      input_in     = input_ff;
      decode_in    = decode_ff;
      out_held_in  = out_held_ff;
      out_done_in  = out_done_ff;
      encode_in    = encode_ff;
      committed_in = committed_ff;
      reserved_in  = reserved_ff;
      acc          = 1'b0;
      ms_out       = MS_NONE;
      priority if (word.op == OP_START) begin
         chosen_in    = '0;
         input_in     = 1'b0;
         decode_in    = 1'b0;
         out_held_in  = 1'b0;
         out_done_in  = 1'b0;
         encode_in    = 1'b0;
         committed_in = MS_NONE;
         reserved_in  = MS_NONE;
         active_in    = (cfg.expected_gen != '0) && (cfg.watermark != '0);
         acc          = active_in;
      end else if (word.op == OP_STOP) begin
         active_in = 1'b0;
         acc       = 1'b1;
      end else if (word.op <= OP_COMMIT_MS && active_ff) begin
         unique case (word.op)
            OP_SELECT: begin
               if (word.generation != cfg.expected_gen) begin
                  active_in = 1'b0;
               end else if (none_chosen && word.is_keyframe &&
                            word.sequence_req > cfg.watermark) begin
                  chosen_in = word.sequence_req;
                  acc       = 1'b1;
               end
            end
            OP_INPUT_RES: begin
               if (!word.ok || none_chosen || input_ff) begin
                  active_in = 1'b0;
               end else begin
                  input_in = 1'b1;
                  acc      = 1'b1;
               end
            end
            OP_DECODED: begin
               if (!word.ok || none_chosen || decode_ff) begin
                  active_in = 1'b0;
               end else begin
                  decode_in = 1'b1;
                  acc       = 1'b1;
               end
            end
            OP_RSV_OUTPUT: begin
               if (!out_held_ff && committed_ff == MS_DECODED) begin
                  out_held_in = 1'b1;
                  acc         = 1'b1;
               end
            end
            OP_OUTPUT_RES: begin
               if (!word.ok || !out_held_ff || out_done_ff) begin
                  active_in = 1'b0;
               end else begin
                  out_done_in = 1'b1;
                  acc         = 1'b1;
               end
            end
            OP_ENCODED: begin
               if (!word.ok || !out_held_ff || encode_ff) begin
                  active_in = 1'b0;
               end else begin
                  encode_in = 1'b1;
                  acc       = 1'b1;
               end
            end
            OP_RSV_MS: begin
               if (reserved_ff == MS_NONE) begin
                  priority if (committed_ff == MS_NONE && input_ff) begin
                     reserved_in = MS_INPUT;
                  end else if (committed_ff == MS_INPUT && decode_ff) begin
                     reserved_in = MS_DECODED;
                  end else if (committed_ff == MS_DECODED && out_done_ff && encode_ff) begin
                     reserved_in = MS_ENCODED;
                  end else begin
                     reserved_in = MS_NONE;
                  end
                  ms_out = reserved_in;
                  acc    = (reserved_in != MS_NONE);
               end
            end
            default: begin
               // commit
               if (!word.ok || word.milestone_in == MS_NONE ||
                   word.milestone_in != reserved_ff) begin
                  active_in = 1'b0;
               end else begin
                  committed_in = word.milestone_in;
                  reserved_in  = MS_NONE;
                  acc          = 1'b1;
               end
            end
         endcase
      end else begin
         acc = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         chosen_ff    <= '0;
         input_ff     <= 1'b0;
         decode_ff    <= 1'b0;
         out_held_ff  <= 1'b0;
         out_done_ff  <= 1'b0;
         encode_ff    <= 1'b0;
         committed_ff <= MS_NONE;
         reserved_ff  <= MS_NONE;
      end else if (fire) begin
         active_ff    <= active_in;
         chosen_ff    <= chosen_in;
         input_ff     <= input_in;
         decode_ff    <= decode_in;
         out_held_ff  <= out_held_in;
         out_done_ff  <= out_done_in;
         encode_ff    <= encode_in;
         committed_ff <= committed_in;
         reserved_ff  <= reserved_in;
      end
   end

   assign result.accepted      = acc;
   assign result.milestone_out = ms_out;
   assign result.armed         = active_in;
   assign result.complete      = active_in && (committed_in == MS_ENCODED);

endmodule

// ===== sv/video_frame_proof_sequencer_unit.sv =====
`timescale 1ns / 1ps
// video_frame_proof_sequencer_unit: top level of the frame proof sequencer
// depends on vfps_pkg, vfps_csr and vfps_engine
//
// usage
//  req channel: one event word per accepted cycle (req_valid high, req_stall low)
//  rsp channel: one result word per event, in event order (rsp_valid, rsp_stall)
//  csr channel: writes source generation (index 0) or watermark (index 1);
//   write only while no event is in flight
//  path: an accepted event waits in the input register until the result
//   register is free, then rsp_valid rises with its result word
//  throughput: one event per cycle while rsp_stall is low; the input register and the result
//   register are separate, so a new event is taken while a result waits
//  the state update is 32-bit compares and flag logic between the input
//   register and the result register, and sets the single-cycle rate
//  reset: clears the sequencer state, both csr registers and both valid
//   flags; req_stall is high and csr_ready low during reset
//  stall: while rsp_stall holds a result, one more event is buffered in the
//   input register, after which req_stall rises

module video_frame_proof_sequencer_unit
   import vfps_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_word_type               req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_word_type               rsp_word,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]      csr_data
);

   cfg_type      cfg;
   rsp_word_type result;
   logic         in_valid_ff,  in_valid_in;
   req_word_type in_word_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff;
   logic         advance;
   logic         take;

   vfps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   vfps_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .word   (in_word_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = reset || (in_valid_ff && !advance);
   assign take      = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (take) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         out_word_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

// ===== sv/vfps_checker.sv =====
`timescale 1ns / 1ps
// vfps_checker: port-level checks on the frame proof sequencer top level
// depends on vfps_pkg; bound to video_frame_proof_sequencer_unit below

module vfps_checker
   import vfps_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   // held result word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_complete_armed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.complete |-> rsp_word.armed)
      else $error("complete without armed");

   a_ms_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.milestone_out != MS_NONE |-> rsp_word.accepted)
      else $error("milestone reserved but word not accepted");

   // a fresh result follows an event taken through the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result word without a matching event");

endmodule

bind video_frame_proof_sequencer_unit vfps_checker u_vfps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
